[rtl/nrlt_pkg.sv]
// Package for the node registration and liveness table.
// Types, codes and reset constants shared by the modules in rtl/ other than nrlt_ram.
`default_nettype none

package nrlt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int SLOT_NUM_W    = 8;
    localparam int NODE_ID_W     = 16;
    localparam int MAC_W         = 24;
    localparam int TIME_W        = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 1;
    localparam int COUNT_OUT_W   = 5;
    localparam int S_TDATA_W     = 88;
    localparam int S_TUSER_W     = 3;
    localparam int M_TDATA_W     = 40;
    localparam int M_TUSER_W     = 3;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

    typedef enum logic [2:0] {
        REQ_REGISTER  = 3'd0,
        REQ_CONFIRM   = 3'd1,
        REQ_HEARTBEAT = 3'd2,
        REQ_STATUS    = 3'd3,
        REQ_TICK      = 3'd4
    } req_kind_t;

    typedef enum logic [2:0] {
        RES_OK         = 3'd0,
        RES_RANGE      = 3'd1,
        RES_MISMATCH   = 3'd2,
        RES_FULL       = 3'd3,
        RES_UNREG      = 3'd4
    } result_code_t;

    typedef enum logic [1:0] {
        ST_OFFLINE = 2'd0,
        ST_WAITING = 2'd1,
        ST_ACTIVE  = 2'd2,
        ST_LOST    = 2'd3
    } slot_state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTRAL_ID = 1'b0,
        CFG_TIMEOUT_MS = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_DECODE,
        C_SCAN_RD,
        C_SCAN_EV,
        C_REG_WR,
        C_ONE_RD,
        C_ONE_EV,
        C_TICK_RD,
        C_TICK_EV,
        C_FINISH
    } ctrl_state_t;

    typedef struct packed {
        slot_state_t            status;
        logic [NODE_ID_W-1:0]   node_id;
        logic                   mac_valid;
        logic [MAC_W-1:0]       mac_tail;
        logic [TIME_W-1:0]      last_seen;
    } slot_entry_t;

    typedef struct packed {
        req_kind_t              req_type;
        logic [NODE_ID_W-1:0]   node_id;
        logic [SLOT_NUM_W-1:0]  slot_number;
        logic                   mac_present;
        logic [MAC_W-1:0]       mac_tail;
        logic [TIME_W-1:0]      now_ms;
    } in_item_t;

    typedef struct packed {
        result_code_t           result_code;
        logic                   assign_send;
        logic [NODE_ID_W-1:0]   assign_node_id;
        logic [SLOT_NUM_W-1:0]  assign_slot;
        logic [COUNT_OUT_W-1:0] active_total;
        logic [COUNT_OUT_W-1:0] newly_lost;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic res_init;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic rd_one;
        logic scan_eval;
        logic reg_write;
        logic one_write;
        logic tick_eval;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_kind_t req_type;
        logic      slot_ok;
        logic      idx_last;
        logic      out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

[rtl/nrlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module nrlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/nrlt_ctrl.sv]
// Sequencer for the liveness table: one item at a time, slot scans.
// Depends on nrlt_pkg for command, status and state types.
`default_nettype none

module nrlt_ctrl
    import nrlt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output ctrl_cmd_t       cmd,
    input  wire ctrl_stat_t stat
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = C_DECODE;
                end
            end
            C_DECODE:
            begin
                unique case (stat.req_type) inside
                    REQ_REGISTER:
                        state_next = C_SCAN_RD;
                    REQ_CONFIRM, REQ_HEARTBEAT, REQ_STATUS:
                        state_next = stat.slot_ok ? C_ONE_RD : C_FINISH;
                    REQ_TICK:
                        state_next = C_TICK_RD;
                    default:
                        state_next = C_FINISH;
                endcase
            end
            C_SCAN_RD: state_next = C_SCAN_EV;
            C_SCAN_EV: state_next = stat.idx_last ? C_REG_WR : C_SCAN_RD;
            C_REG_WR:  state_next = C_FINISH;
            C_ONE_RD:  state_next = C_ONE_EV;
            C_ONE_EV:  state_next = C_FINISH;
            C_TICK_RD: state_next = C_TICK_EV;
            C_TICK_EV: state_next = stat.idx_last ? C_FINISH : C_TICK_RD;
            C_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = C_IDLE;
                end
            end
            default:   state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            C_DECODE:
            begin
                cmd.res_init = 1'b1;
                cmd.idx_clr  = 1'b1;
            end
            C_SCAN_RD, C_TICK_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            C_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                cmd.idx_inc   = !stat.idx_last;
            end
            C_REG_WR:
            begin
                cmd.reg_write = 1'b1;
            end
            C_ONE_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_one = 1'b1;
            end
            C_ONE_EV:
            begin
                cmd.one_write = 1'b1;
            end
            C_TICK_EV:
            begin
                cmd.tick_eval = 1'b1;
                cmd.idx_inc   = !stat.idx_last;
            end
            C_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/nrlt_datapath.sv]
// Datapath of the liveness table: slot RAM, valid bits, scan index,
// compare logic, active counter and output register. Uses nrlt_pkg, nrlt_ram.
`default_nettype none

module nrlt_datapath
    import nrlt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_cmd_t         cmd,
    output ctrl_stat_t             stat,
    input  wire in_item_t          in_item,
    input  wire logic [TIME_W-1:0] timeout_ms,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output out_item_t              out_item
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ENTRY_W = $bits(slot_entry_t);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    in_item_t          in_q_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic              hit_found_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    slot_entry_t       hit_word_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    slot_entry_t       free_word_reg;

    result_code_t           code_reg;
    logic                   send_reg;
    logic [NODE_ID_W-1:0]   aid_reg;
    logic [SLOT_NUM_W-1:0]  aslot_reg;
    logic [COUNT_OUT_W-1:0] lost_reg;
    logic                   m_valid_reg;
    out_item_t              out_reg;

    logic [ENTRY_W-1:0] rd_raw;
    slot_entry_t        entry;
    logic [SLOT_W-1:0]  raddr;
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    slot_entry_t        wdata;

    logic [SLOT_NUM_W-1:0] slot_m1;
    logic [SLOT_W-1:0]     slot_idx;
    logic                  slot_req;
    logic                  slot_ok;
    logic                  id_eq;
    logic                  match;
    logic                  hb_mismatch;
    logic                  hb_ok;
    logic [TIME_W-1:0]     age;
    logic                  expire;
    logic [8:0]            cnt_ext;
    slot_entry_t           reg_base;
    logic [SLOT_W-1:0]     reg_idx;

    assign slot_m1  = in_q_reg.slot_number - SLOT_NUM_W'(1);
    assign slot_idx = slot_m1[SLOT_W-1:0];
    assign slot_req = (in_q_reg.req_type == REQ_CONFIRM) ||
                      (in_q_reg.req_type == REQ_HEARTBEAT) ||
                      (in_q_reg.req_type == REQ_STATUS);
    assign slot_ok  = (in_q_reg.slot_number != '0) &&
                      (9'(in_q_reg.slot_number) <= 9'(SLOTS));

    assign raddr = cmd.rd_one ? slot_idx : idx_reg;

    nrlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rd_raw)
    );

    // A slot never written reads as its reset value
    assign entry = rd_valid_reg ? slot_entry_t'(rd_raw) : slot_entry_t'('0);

    assign id_eq       = (entry.node_id == in_q_reg.node_id);
    assign match       = (entry.status != ST_OFFLINE) &&
                         ((in_q_reg.mac_present && entry.mac_valid) ?
                          (entry.mac_tail == in_q_reg.mac_tail) : id_eq);
    assign hb_mismatch = (in_q_reg.node_id != '0) && (entry.node_id != '0) && !id_eq;
    assign hb_ok       = (entry.status != ST_OFFLINE) && !hb_mismatch;
    assign age         = in_q_reg.now_ms - entry.last_seen;
    assign expire      = ((entry.status == ST_ACTIVE) || (entry.status == ST_WAITING)) &&
                         (age > timeout_ms);

    assign reg_base = hit_found_reg ? hit_word_reg : free_word_reg;
    assign reg_idx  = hit_found_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = entry;
        if (cmd.reg_write)
        begin
            we    = hit_found_reg || free_found_reg;
            waddr = reg_idx;
            wdata = reg_base;
            if (!hit_found_reg || (reg_base.status == ST_LOST))
            begin
                wdata.status = ST_WAITING;
            end
            wdata.node_id   = in_q_reg.node_id;
            wdata.last_seen = in_q_reg.now_ms;
            if (in_q_reg.mac_present)
            begin
                wdata.mac_valid = 1'b1;
                wdata.mac_tail  = in_q_reg.mac_tail;
            end
        end
        else if (cmd.one_write)
        begin
            waddr           = slot_idx;
            wdata.last_seen = in_q_reg.now_ms;
            case (in_q_reg.req_type)
                REQ_CONFIRM:
                begin
                    we           = id_eq;
                    wdata.status = ST_ACTIVE;
                end
                REQ_HEARTBEAT:
                begin
                    we = hb_ok;
                    if (entry.status == ST_LOST)
                    begin
                        wdata.status = ST_ACTIVE;
                    end
                end
                REQ_STATUS:
                begin
                    we = 1'b1;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
        else if (cmd.tick_eval)
        begin
            we           = expire;
            wdata.status = ST_LOST;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.one_write)
        begin
            if ((in_q_reg.req_type == REQ_CONFIRM) && id_eq && (entry.status != ST_ACTIVE))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else if ((in_q_reg.req_type == REQ_HEARTBEAT) && hb_ok &&
                     (entry.status == ST_LOST))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.tick_eval && expire && (entry.status == ST_ACTIVE))
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            cnt_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.res_init)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan_eval)
            begin
                if (!hit_found_reg && match)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!free_found_reg && (entry.status == ST_OFFLINE))
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_q_reg <= in_item;
        end
        if (cmd.scan_eval)
        begin
            if (!hit_found_reg && match)
            begin
                hit_idx_reg  <= idx_reg;
                hit_word_reg <= entry;
            end
            if (!free_found_reg && (entry.status == ST_OFFLINE))
            begin
                free_idx_reg  <= idx_reg;
                free_word_reg <= entry;
            end
        end
        if (cmd.res_init)
        begin
            code_reg  <= (slot_req && !slot_ok) ? RES_RANGE : RES_OK;
            send_reg  <= 1'b0;
            aid_reg   <= '0;
            aslot_reg <= '0;
            lost_reg  <= '0;
        end
        if (cmd.reg_write)
        begin
            if (hit_found_reg || free_found_reg)
            begin
                send_reg  <= 1'b1;
                aid_reg   <= in_q_reg.node_id;
                aslot_reg <= SLOT_NUM_W'(reg_idx) + SLOT_NUM_W'(1);
            end
            else
            begin
                code_reg <= RES_FULL;
            end
        end
        if (cmd.one_write)
        begin
            case (in_q_reg.req_type)
                REQ_CONFIRM:
                begin
                    if (!id_eq)
                    begin
                        code_reg <= RES_MISMATCH;
                    end
                end
                REQ_HEARTBEAT:
                begin
                    if (entry.status == ST_OFFLINE)
                    begin
                        code_reg <= RES_UNREG;
                    end
                    else if (hb_mismatch)
                    begin
                        code_reg <= RES_MISMATCH;
                    end
                    else if (entry.status == ST_WAITING)
                    begin
                        send_reg  <= 1'b1;
                        aid_reg   <= entry.node_id;
                        aslot_reg <= in_q_reg.slot_number;
                    end
                end
                default:
                begin
                    code_reg <= code_reg;
                end
            endcase
        end
        if (cmd.tick_eval && expire && (lost_reg != COUNT_OUT_W'(31)))
        begin
            lost_reg <= lost_reg + COUNT_OUT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_reg.result_code    <= code_reg;
            out_reg.assign_send    <= send_reg;
            out_reg.assign_node_id <= aid_reg;
            out_reg.assign_slot    <= aslot_reg;
            out_reg.active_total   <= (cnt_ext > 9'd31) ? COUNT_OUT_W'(31) :
                                      cnt_ext[COUNT_OUT_W-1:0];
            out_reg.newly_lost     <= lost_reg;
        end
    end

    assign cnt_ext = 9'(cnt_reg);

    assign stat.req_type = in_q_reg.req_type;
    assign stat.slot_ok  = slot_ok;
    assign stat.idx_last = (idx_reg == LAST_IDX);
    assign stat.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign out_item = out_reg;

endmodule

`default_nettype wire

[rtl/node_registration_liveness_table_core.sv]
// Top level of the node registration and liveness table.
// Depends on nrlt_pkg, nrlt_ctrl, nrlt_datapath and nrlt_ram.
//
// The block keeps SLOTS node slots in one RAM word each (status, node id, MAC
// tail, last-seen time) plus one valid flop per slot, so the table reads as
// all offline straight out of reset with no clearing pass. Items are handled
// one at a time. A register item scans every slot, each slot read from RAM
// and then compared, and afterwards writes the chosen slot back. A timeout
// tick walks the table the same way but has no separate write-back step at
// the end. Confirm, heartbeat and status items touch one slot; an out of
// range slot or an unknown request type skips the RAM and goes straight to
// the result. The single RAM read port is why the slots are read one by one.
// One result is produced per item and held in an output register, so a new
// item is taken as soon as the previous one is finished; the block only waits
// when the output register is still full at the end of an item. The active
// count is kept incrementally and reported saturated at 31. Register
// central_id is accepted on the config port but drives no output of this
// block; timeout_ms resets to 30000.
`default_nettype none

module node_registration_liveness_table_core
    import nrlt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input transactions
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // node_id[15:0], slot_number[23:16], mac_present[24], mac_tail[48:25],
    // now_ms[80:49], zero fill
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // req_type[2:0]
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    // Result transactions
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // assign_send[0], assign_node_id[16:1], assign_slot[24:17],
    // active_total[29:25], newly_lost[34:30], zero fill
    output logic      [M_TDATA_W-1:0]   m_tdata,
    // result_code[2:0]
    output logic      [M_TUSER_W-1:0]   m_tuser,
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [TIME_W-1:0] timeout_reg;
    ctrl_cmd_t         cmd;
    ctrl_stat_t        stat;
    in_item_t          in_item;
    out_item_t         out_item;

    // Config writes are always taken; only the timeout is stored here
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && (cfg_index == CFG_TIMEOUT_MS))
        begin
            timeout_reg <= cfg_data;
        end
    end

    // Unpack the input transaction
    assign in_item.req_type    = req_kind_t'(s_tuser);
    assign in_item.node_id     = s_tdata[15:0];
    assign in_item.slot_number = s_tdata[23:16];
    assign in_item.mac_present = s_tdata[24];
    assign in_item.mac_tail    = s_tdata[48:25];
    assign in_item.now_ms      = s_tdata[80:49];

    nrlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    nrlt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_item    (in_item),
        .timeout_ms (timeout_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_item   (out_item)
    );

    // Pack the result transaction
    assign m_tdata = {5'b0,
                      out_item.newly_lost,
                      out_item.active_total,
                      out_item.assign_slot,
                      out_item.assign_node_id,
                      out_item.assign_send};
    assign m_tuser = out_item.result_code;

endmodule

`default_nettype wire

[tb/tb_node_registration_liveness_table_core.sv]
// Self-checking testbench for node_registration_liveness_table_core.
// Depends on nrlt_pkg and the core RTL. Predicts each result from a local copy of the
// slot table and compares it with what the block sends back.
`timescale 1ns / 1ps

module tb_node_registration_liveness_table_core;
    import nrlt_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;
    // Request codes above the tick are undefined and must be answered as a no-op
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
    // Cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 166;
    localparam int PHASES = 5;

    typedef struct packed {
        logic [2:0]  req_code;
        logic [15:0] node_id;
        logic [7:0]  slot;
        logic        mac_present;
        logic [23:0] mac_tail;
        logic [31:0] now;
    } request_t;

    typedef struct packed {
        logic [2:0]  code;
        logic        send;
        logic [15:0] assign_id;
        logic [7:0]  assign_slot;
        logic [4:0]  active;
        logic [4:0]  lost;
    } response_t;

    // Local copy of the slot table; predicts one response per accepted request
    // and keeps the responses still owed by the block.
    class registration_scoreboard;
        slot_state_t  status[SLOTS];
        logic [15:0]  node_id[SLOTS];
        logic [23:0]  mac_tail[SLOTS];
        logic         mac_valid[SLOTS];
        logic [31:0]  last_seen[SLOTS];
        logic [31:0]  central_id;
        logic [31:0]  timeout_ms;
        response_t    pending[$];
        int           errors;
        int           checked;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                status[i]    = ST_OFFLINE;
                node_id[i]   = '0;
                mac_valid[i] = 1'b0;
                last_seen[i] = '0;
            end
            central_id = 32'hCE00;
            timeout_ms = TIMEOUT_RESET;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [31:0] value);
            if (idx == CFG_CENTRAL_ID)
                central_id = value;
            else
                timeout_ms = value;
        endfunction

        function response_t apply_request(request_t rq);
            response_t   rs;
            int          hit;
            int          k;
            int          n_active;
            logic [31:0] silent_for;
            rs  = '0;
            hit = -1;
            k   = int'(rq.slot) - 1;
            case (rq.req_code)
                REQ_REGISTER:
                begin
                    // Match by MAC tail where both sides carry one, else by id
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (hit < 0 && status[i] != ST_OFFLINE)
                        begin
                            if (rq.mac_present && mac_valid[i])
                            begin
                                if (mac_tail[i] == rq.mac_tail)
                                    hit = i;
                            end
                            else if (node_id[i] == rq.node_id)
                                hit = i;
                        end
                    end
                    if (hit < 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (hit < 0 && status[i] == ST_OFFLINE)
                            begin
                                hit       = i;
                                status[i] = ST_WAITING;
                            end
                        end
                    end
                    else if (status[hit] == ST_LOST)
                        status[hit] = ST_WAITING;
                    if (hit < 0)
                        rs.code = RES_FULL;
                    else
                    begin
                        node_id[hit] = rq.node_id;
                        if (rq.mac_present)
                        begin
                            mac_tail[hit]  = rq.mac_tail;
                            mac_valid[hit] = 1'b1;
                        end
                        last_seen[hit] = rq.now;
                        rs.send        = 1'b1;
                        rs.assign_id   = rq.node_id;
                        rs.assign_slot = 8'(hit + 1);
                    end
                end
                REQ_CONFIRM, REQ_HEARTBEAT, REQ_STATUS:
                begin
                    if (rq.slot < 1 || rq.slot > SLOTS)
                        rs.code = RES_RANGE;
                    else if (rq.req_code == REQ_CONFIRM)
                    begin
                        if (node_id[k] == rq.node_id)
                        begin
                            status[k]    = ST_ACTIVE;
                            last_seen[k] = rq.now;
                        end
                        else
                            rs.code = RES_MISMATCH;
                    end
                    else if (rq.req_code == REQ_HEARTBEAT)
                    begin
                        if (status[k] == ST_OFFLINE)
                            rs.code = RES_UNREG;
                        else if (rq.node_id != 0 && node_id[k] != 0 &&
                                 node_id[k] != rq.node_id)
                            rs.code = RES_MISMATCH;
                        else
                        begin
                            last_seen[k] = rq.now;
                            if (status[k] == ST_LOST)
                                status[k] = ST_ACTIVE;
                            else if (status[k] == ST_WAITING)
                            begin
                                rs.send        = 1'b1;
                                rs.assign_id   = node_id[k];
                                rs.assign_slot = rq.slot;
                            end
                        end
                    end
                    else
                        last_seen[k] = rq.now;
                end
                REQ_TICK:
                begin
                    // Wrapping distance since last contact, strictly beyond the timeout
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        silent_for = rq.now - last_seen[i];
                        if ((status[i] == ST_ACTIVE || status[i] == ST_WAITING) &&
                            silent_for > timeout_ms)
                        begin
                            status[i] = ST_LOST;
                            if (rs.lost < 5'd31)
                                rs.lost = rs.lost + 5'd1;
                        end
                    end
                end
                default: ;
            endcase
            n_active = 0;
            for (int i = 0; i < SLOTS; i++)
                if (status[i] == ST_ACTIVE)
                    n_active++;
            rs.active = (n_active > 31) ? 5'd31 : 5'(n_active);
            return rs;
        endfunction

        function void note_request(request_t rq);
            pending.push_back(apply_request(rq));
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10)
                $display("%0t: response %0d: %s expected 0x%0h, got 0x%0h",
                         $time, checked, field, want, got);
        endfunction

        function void check_response(logic [2:0] code, logic [M_TDATA_W-1:0] data);
            response_t want;
            if (pending.size() == 0)
            begin
                report("unexpected response, code", '0, code);
                return;
            end
            want = pending.pop_front();
            if (code != want.code)
                report("result_code", want.code, code);
            if (data[0] != want.send)
                report("assign_send", want.send, data[0]);
            if (data[16:1] != want.assign_id)
                report("assign_node_id", want.assign_id, data[16:1]);
            if (data[24:17] != want.assign_slot)
                report("assign_slot", want.assign_slot, data[24:17]);
            if (data[29:25] != want.active)
                report("active_total", want.active, data[29:25]);
            if (data[34:30] != want.lost)
                report("newly_lost", want.lost, data[34:30]);
            checked++;
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    registration_scoreboard sb = new();

    // Shared pacing state: calm suppresses idling on both sides for a stretch
    logic        calm = 1'b0;
    logic [31:0] now_cur = 32'd100;
    logic [31:0] step_ceiling = 32'd1000;
    int          idle_cycles = 0;

    node_registration_liveness_table_core #(
        .SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic request_t make_request(logic [2:0] kind, logic [15:0] id,
                                              logic [7:0] slot, logic macp,
                                              logic [23:0] mac, logic [31:0] now);
        request_t rq;
        rq.req_code    = kind;
        rq.node_id     = id;
        rq.slot        = slot;
        rq.mac_present = macp;
        rq.mac_tail    = mac;
        rq.now         = now;
        return rq;
    endfunction

    // Advance the node-side clock: mostly small steps relative to the timeout,
    // sometimes a jump anywhere so the time wraps and every bit toggles.
    task automatic advance_time();
        if ($urandom_range(0, 7) == 0)
            now_cur = now_cur + $urandom;
        else
            now_cur = now_cur + $urandom_range(0, step_ceiling);
    endtask

    // Build a request that mostly names real slots with their stored ids and
    // MAC tails, so confirm, heartbeat and re-register reach the deeper states.
    function automatic request_t random_request();
        request_t rq;
        int       pick;
        int       j;
        int       r;
        pick           = $urandom_range(0, 99);
        j              = $urandom_range(0, SLOTS - 1);
        rq.now         = ($urandom_range(0, 39) == 0) ? $urandom : now_cur;
        rq.node_id     = 16'($urandom);
        rq.mac_tail    = 24'($urandom);
        rq.mac_present = 1'($urandom_range(0, 1));
        rq.slot        = 8'(j + 1);
        if (pick < 26)
        begin
            rq.req_code = REQ_REGISTER;
            r = $urandom_range(0, 3);
            if (r == 0)
                rq.node_id = 16'($urandom_range(0, 24));
            else if (r < 3)
            begin
                rq.node_id = sb.node_id[j];
                if (sb.mac_valid[j])
                    rq.mac_tail = sb.mac_tail[j];
                if ($urandom_range(0, 3) == 0)
                    rq.node_id = 16'($urandom);
            end
            if ($urandom_range(0, 5) == 0)
                rq.mac_tail = 24'($urandom_range(0, 7));
        end
        else if (pick < 46)
        begin
            rq.req_code = REQ_CONFIRM;
            if ($urandom_range(0, 4) != 0)
                rq.node_id = sb.node_id[j];
        end
        else if (pick < 72)
        begin
            rq.req_code = REQ_HEARTBEAT;
            r = $urandom_range(0, 4);
            if (r < 3)
                rq.node_id = sb.node_id[j];
            else if (r == 3)
                rq.node_id = '0;
        end
        else if (pick < 82)
            rq.req_code = REQ_STATUS;
        else if (pick < 95)
            rq.req_code = REQ_TICK;
        else
            rq.req_code = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        // Occasionally aim a slot request outside the table
        if ((rq.req_code == REQ_CONFIRM || rq.req_code == REQ_HEARTBEAT ||
             rq.req_code == REQ_STATUS) && $urandom_range(0, 11) == 0)
            rq.slot = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(SLOTS + 1, 255));
        return rq;
    endfunction

    // Present one request and hold it until the block takes it; keep tvalid
    // high across back-to-back requests.
    task automatic push_request(request_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, rq.now, rq.mac_tail, rq.mac_present, rq.slot, rq.node_id};
        s_tuser  <= rq.req_code;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(rq);
    endtask

    // Hold off new requests until every owed response has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: check each transaction, then pick the next ready value
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_response(m_tuser, m_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: any transaction on any port restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [31:0] phase_timeout[PHASES];
        logic [31:0] phase_central[PHASES];
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CENTRAL_ID;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the reset configuration (timeout 30000)
        // Tick on an empty table
        push_request(make_request(REQ_TICK, 16'h0000, 8'd0, 1'b0, 24'h000000, 32'd0));
        // First register takes slot 1; second misses by id and takes slot 2
        push_request(make_request(REQ_REGISTER, 16'hFFFF, 8'd0, 1'b1, 24'hFFFFFF, 32'd100));
        push_request(make_request(REQ_REGISTER, 16'h0000, 8'd0, 1'b0, 24'h000000, 32'd200));
        // Same MAC with a new id matches slot 1 and renames it
        push_request(make_request(REQ_REGISTER, 16'h1234, 8'd0, 1'b1, 24'hFFFFFF, 32'd300));
        // Slot out of range on each slot-addressed request
        push_request(make_request(REQ_CONFIRM, 16'h1234, 8'd0, 1'b0, 24'h000000, 32'd300));
        push_request(make_request(REQ_HEARTBEAT, 16'h1234, 8'd17, 1'b0, 24'h000000, 32'd300));
        push_request(make_request(REQ_STATUS, 16'h1234, 8'd255, 1'b1, 24'hFFFFFF, 32'd300));
        // Confirm with the wrong id, then the right one
        push_request(make_request(REQ_CONFIRM, 16'h4321, 8'd1, 1'b0, 24'h000000, 32'd350));
        push_request(make_request(REQ_CONFIRM, 16'h1234, 8'd1, 1'b0, 24'h000000, 32'd400));
        // Confirm on an offline slot holding id 0 activates it
        push_request(make_request(REQ_CONFIRM, 16'h0000, 8'd5, 1'b0, 24'h000000, 32'd500));
        // Heartbeat on an offline slot is rejected as unregistered
        push_request(make_request(REQ_HEARTBEAT, 16'h0000, 8'd6, 1'b0, 24'h000000, 32'd550));
        // Heartbeat on a waiting slot resends the assignment
        push_request(make_request(REQ_HEARTBEAT, 16'h0000, 8'd2, 1'b0, 24'h000000, 32'd600));
        // Heartbeat id mismatch, then wildcard id on an active slot
        push_request(make_request(REQ_HEARTBEAT, 16'hBEEF, 8'd1, 1'b0, 24'h000000, 32'd650));
        push_request(make_request(REQ_HEARTBEAT, 16'h0000, 8'd1, 1'b0, 24'h000000, 32'd700));
        // Status on an offline slot refreshes time only
        push_request(make_request(REQ_STATUS, 16'h0000, 8'd7, 1'b0, 24'h000000, 32'd800));
        // Undefined request codes
        push_request(make_request(REQ_UNKNOWN_LO, 16'h0000, 8'd1, 1'b0, 24'h000000, 32'd800));
        push_request(make_request(REQ_UNKNOWN_HI, 16'hFFFF, 8'hFF, 1'b1, 24'hFFFFFF,
                                  32'hFFFF_FFFF));
        // Slot 1 sits exactly at the timeout and survives; slots 2 and 5 go lost
        push_request(make_request(REQ_TICK, 16'h0000, 8'd0, 1'b0, 24'h000000, 32'd30700));
        push_request(make_request(REQ_TICK, 16'h0000, 8'd0, 1'b0, 24'h000000, 32'hFFFF_FFFF));
        // Heartbeat revives a lost slot
        push_request(make_request(REQ_HEARTBEAT, 16'h1234, 8'd1, 1'b0, 24'h000000,
                                  32'hFFFF_FFFF));
        // Register of a lost entry moves it to waiting; time has wrapped
        push_request(make_request(REQ_REGISTER, 16'h0000, 8'd0, 1'b0, 24'h000000, 32'd5));
        // No MAC or id match: takes the first offline slot
        push_request(make_request(REQ_REGISTER, 16'h0001, 8'd0, 1'b1, 24'h000000, 32'd5));
        // Wrapped distances stay small: nothing is lost
        push_request(make_request(REQ_TICK, 16'h0000, 8'd0, 1'b0, 24'h000000, 32'd20));

        // Random phases, each under its own configuration
        phase_timeout[0] = 32'd0;
        phase_central[0] = 32'd0;
        phase_timeout[1] = 32'hFFFF_FFFF;
        phase_central[1] = 32'hFFFF_FFFF;
        phase_timeout[2] = 32'd1000;
        phase_central[2] = $urandom;
        phase_timeout[3] = $urandom;
        phase_central[3] = $urandom;
        phase_timeout[4] = TIMEOUT_RESET;
        phase_central[4] = 32'hCE00;
        now_cur = 32'd40;
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_register(CFG_CENTRAL_ID, phase_central[p]);
            write_register(CFG_TIMEOUT_MS, phase_timeout[p]);
            step_ceiling = (phase_timeout[p] >> 2) + 32'd2;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                advance_time();
                push_request(random_request());
            end
        end

        // Let the last responses come back, then leave room for strays
        calm = 1'b0;
        drain_results();
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
